/* src/bbwp_pkg.sv */
// ----------------------------------------------------------------------------
// bbwp_pkg : shared types, constants and step functions
// Register codes, pipeline records and the per-stage square root and
// divider steps of the blend-weight brush painter.
// ----------------------------------------------------------------------------
package bbwp_pkg;

    localparam int NUM_CH     = 8;
    localparam int SQ_STEPS   = 14;   // root bits of a 28-bit radicand
    localparam int DV_STEPS   = 21;   // quotient bits of the 21-bit numerator
    localparam int ND_STEPS   = 8;    // normalized weight is below 256
    localparam int NST        = 2 + SQ_STEPS + 1 + DV_STEPS + 1 + 1 + ND_STEPS + 1;

    localparam logic [15:0] WEIGHT_SAT  = 16'hFFFF;
    localparam logic [13:0] DIST_ONE_Q4 = 14'd16;

    typedef enum logic [3:0] {
        REG_RADIUS  = 4'd0,
        REG_OPACITY = 4'd1,
        REG_FALLOFF = 4'd2,
        REG_CHANNEL = 4'd3
    } reg_code_t;

    // side data that travels with every pixel
    typedef struct packed {
        logic            in_brush;
        logic [7:0][7:0] w;
    } carry_t;

    typedef struct packed {
        logic [27:0] n;
        logic [13:0] root;
        logic [16:0] rem;
    } sq_t;

    typedef struct packed {
        logic [20:0] n;
        logic [25:0] rem;
        logic [20:0] q;
    } dv_t;

    // one digit of the integer square root
    function automatic sq_t sq_step(input sq_t s);
        sq_t         r;
        logic [16:0] rem2;
        logic [16:0] trial;
        rem2  = {s.rem[14:0], s.n[27:26]};
        trial = {1'b0, s.root, 2'b01};
        r.n   = {s.n[25:0], 2'b00};
        if (rem2 >= trial)
        begin
            r.rem  = rem2 - trial;
            r.root = {s.root[12:0], 1'b1};
        end
        else
        begin
            r.rem  = rem2;
            r.root = {s.root[12:0], 1'b0};
        end
        return r;
    endfunction

    // one quotient bit of the increment divider
    function automatic dv_t dv_step(input dv_t s, input logic [25:0] den);
        dv_t         r;
        logic [26:0] rem2;
        logic [26:0] diff;
        rem2 = {s.rem, s.n[20]};
        diff = rem2 - {1'b0, den};
        r.n  = {s.n[19:0], 1'b0};
        if (rem2 >= {1'b0, den})
        begin
            r.rem = diff[25:0];
            r.q   = {s.q[19:0], 1'b1};
        end
        else
        begin
            r.rem = rem2[25:0];
            r.q   = {s.q[19:0], 1'b0};
        end
        return r;
    endfunction

endpackage

/* src/brush_blend_weight_paint.sv */
// ----------------------------------------------------------------------------
// brush_blend_weight_paint : blend-weight brush painter
// Paints one pixel of an eight-channel weight map per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per pixel, offset from brush center plus eight weights.
//   out_* : one beat per pixel, eight new weights plus the painted flag.
//   cfg_* : register writes (0 radius, 1 opacity, 2 falloff, 3 channel);
//           cfg_ready is always high. Write only while the pipe is empty.
// Throughput is one pixel per clock while the output is not stalled. The
// 14-step square root and the 21-step increment divider, one bit per stage,
// set the depth.
// The whole pipe advances as one: when out_valid is high and out_ready low,
// everything holds and in_ready drops; bubbles do not compact.
// Reset empties the pipe and loads radius 0, opacity 128, falloff 128,
// channel 0.
// ----------------------------------------------------------------------------
module brush_blend_weight_paint
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [10:0] offset_x,
    input  logic signed [10:0] offset_y,
    input  logic [7:0]         weight_0,
    input  logic [7:0]         weight_1,
    input  logic [7:0]         weight_2,
    input  logic [7:0]         weight_3,
    input  logic [7:0]         weight_4,
    input  logic [7:0]         weight_5,
    input  logic [7:0]         weight_6,
    input  logic [7:0]         weight_7,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         new_weight_0,
    output logic [7:0]         new_weight_1,
    output logic [7:0]         new_weight_2,
    output logic [7:0]         new_weight_3,
    output logic [7:0]         new_weight_4,
    output logic [7:0]         new_weight_5,
    output logic [7:0]         new_weight_6,
    output logic [7:0]         new_weight_7,
    output logic               painted
);

    localparam int NST = bbwp_pkg::NST;
    localparam int SQ0 = 2;
    localparam int DEN = SQ0 + bbwp_pkg::SQ_STEPS;
    localparam int DV0 = DEN + 1;
    localparam int INC = DV0 + bbwp_pkg::DV_STEPS;
    localparam int SUM = INC + 1;
    localparam int ND0 = SUM + 1;
    localparam int OUT = ND0 + bbwp_pkg::ND_STEPS;

    // configuration
    logic [9:0]  radius_reg;
    logic [8:0]  opacity_reg;
    logic [11:0] falloff_reg;
    logic [2:0]  channel_reg;
    logic [19:0] r2_reg;
    logic [20:0] num_reg;

    // global advance of the pipe
    logic adv;
    logic vld_reg [NST];
    bbwp_pkg::carry_t c_reg [OUT];

    assign adv       = !vld_reg[OUT] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[OUT];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= '0;
            opacity_reg <= 9'd128;
            falloff_reg <= 12'd128;
            channel_reg <= '0;
            r2_reg      <= '0;
            num_reg     <= 21'd522240;
        end
        else
        begin
            // derived terms are registered in the cycle after a write, well before any pixel
            r2_reg  <= 20'(radius_reg * radius_reg);
            num_reg <= ({12'd0, opacity_reg} << 12) - ({12'd0, opacity_reg} << 4);
            if (cfg_valid)
            begin
                case (cfg_index)
                    bbwp_pkg::REG_RADIUS:  radius_reg  <= cfg_data[9:0];
                    bbwp_pkg::REG_OPACITY: opacity_reg <= cfg_data[8:0];
                    bbwp_pkg::REG_FALLOFF: falloff_reg <= cfg_data;
                    bbwp_pkg::REG_CHANNEL: channel_reg <= cfg_data[2:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NST; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < NST; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    // stage 0: absolute offsets squared
    logic [10:0] ax;
    logic [10:0] ay;
    logic [20:0] ax2_reg;
    logic [20:0] ay2_reg;
    bbwp_pkg::carry_t c_in;

    assign ax = offset_x[10] ? (~offset_x + 11'd1) : offset_x;
    assign ay = offset_y[10] ? (~offset_y + 11'd1) : offset_y;

    always_comb
    begin
        c_in.in_brush = 1'b0;
        c_in.w        = {weight_7, weight_6, weight_5, weight_4,
                         weight_3, weight_2, weight_1, weight_0};
    end

    // stage 1: squared distance and the inside test
    logic [21:0] d2_next;
    logic [19:0] d2_reg;
    assign d2_next = {1'b0, ax2_reg} + {1'b0, ay2_reg};

    // square root, divider and normalizer records
    bbwp_pkg::sq_t sq_reg [bbwp_pkg::SQ_STEPS];
    logic [13:0]   dq;
    logic [25:0]   den_reg;
    bbwp_pkg::dv_t dv_reg [bbwp_pkg::DV_STEPS];
    logic [25:0]   dden_reg [bbwp_pkg::DV_STEPS];
    logic [15:0]   inc_sat;
    logic [16:0]   act_sum;
    logic [7:0][15:0] wl_next;
    logic [7:0][15:0] wl_reg;
    logic [16:0]   sum_next;
    logic [16:0]   sum_reg;
    logic [7:0][23:0] nm_reg;
    logic [7:0][23:0] nd_rem_reg [bbwp_pkg::ND_STEPS];
    logic [7:0][7:0]  nd_q_reg   [bbwp_pkg::ND_STEPS];
    logic [16:0]      nd_sum_reg [bbwp_pkg::ND_STEPS];
    logic [7:0][7:0]  out_w_reg;
    logic             painted_reg;

    assign dq = (sq_reg[bbwp_pkg::SQ_STEPS-1].root < bbwp_pkg::DIST_ONE_Q4)
              ? bbwp_pkg::DIST_ONE_Q4 : sq_reg[bbwp_pkg::SQ_STEPS-1].root;

    // increment: a zero divisor or an oversized quotient saturates
    always_comb
    begin
        if ((dden_reg[bbwp_pkg::DV_STEPS-1] == '0) ||
            (dv_reg[bbwp_pkg::DV_STEPS-1].q[20:16] != '0))
            inc_sat = bbwp_pkg::WEIGHT_SAT;
        else
            inc_sat = dv_reg[bbwp_pkg::DV_STEPS-1].q[15:0];
        act_sum = {9'd0, c_reg[INC-1].w[channel_reg]} + {1'b0, inc_sat};
        for (int i = 0; i < bbwp_pkg::NUM_CH; i++)
            wl_next[i] = {8'd0, c_reg[INC-1].w[i]};
        wl_next[channel_reg] = act_sum[16] ? bbwp_pkg::WEIGHT_SAT : act_sum[15:0];
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < bbwp_pkg::NUM_CH; i++)
            sum_next = sum_next + {1'b0, wl_reg[i]};
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax2_reg <= 21'(ax * ax);
            ay2_reg <= 21'(ay * ay);
            c_reg[0] <= c_in;

            d2_reg            <= d2_next[19:0];
            c_reg[1].w        <= c_reg[0].w;
            c_reg[1].in_brush <= (d2_next < {2'd0, r2_reg});

            for (int s = 2; s < OUT; s++)
                c_reg[s] <= c_reg[s-1];

            sq_reg[0] <= bbwp_pkg::sq_step({d2_reg, 8'd0, 14'd0, 17'd0});
            for (int k = 1; k < bbwp_pkg::SQ_STEPS; k++)
                sq_reg[k] <= bbwp_pkg::sq_step(sq_reg[k-1]);

            den_reg <= 26'(dq * falloff_reg);

            dv_reg[0]   <= bbwp_pkg::dv_step({num_reg, 26'd0, 21'd0}, den_reg);
            dden_reg[0] <= den_reg;
            for (int k = 1; k < bbwp_pkg::DV_STEPS; k++)
            begin
                dv_reg[k]   <= bbwp_pkg::dv_step(dv_reg[k-1], dden_reg[k-1]);
                dden_reg[k] <= dden_reg[k-1];
            end

            wl_reg <= wl_next;

            sum_reg <= sum_next;
            for (int i = 0; i < bbwp_pkg::NUM_CH; i++)
                nm_reg[i] <= ({8'd0, wl_reg[i]} << 8) - {8'd0, wl_reg[i]};

            // normalizer: compare against sum shifted, one quotient bit a stage
            nd_sum_reg[0] <= sum_reg;
            for (int i = 0; i < bbwp_pkg::NUM_CH; i++)
            begin
                if (nm_reg[i] >= ({7'd0, sum_reg} << 7))
                begin
                    nd_rem_reg[0][i] <= nm_reg[i] - ({7'd0, sum_reg} << 7);
                    nd_q_reg[0][i]   <= 8'd1;
                end
                else
                begin
                    nd_rem_reg[0][i] <= nm_reg[i];
                    nd_q_reg[0][i]   <= 8'd0;
                end
            end
            for (int k = 1; k < bbwp_pkg::ND_STEPS; k++)
            begin
                nd_sum_reg[k] <= nd_sum_reg[k-1];
                for (int i = 0; i < bbwp_pkg::NUM_CH; i++)
                begin
                    logic [23:0] rin;
                    logic [7:0]  qin;
                    logic [23:0] sh;
                    rin = nd_rem_reg[k-1][i];
                    qin = nd_q_reg[k-1][i];
                    sh  = {7'd0, nd_sum_reg[k-1]} << (7 - k);
                    if (rin >= sh)
                    begin
                        nd_rem_reg[k][i] <= rin - sh;
                        nd_q_reg[k][i]   <= {qin[6:0], 1'b1};
                    end
                    else
                    begin
                        nd_rem_reg[k][i] <= rin;
                        nd_q_reg[k][i]   <= {qin[6:0], 1'b0};
                    end
                end
            end

            // output: pass-through outside, zeros on an empty sum
            painted_reg <= c_reg[OUT-1].in_brush;
            if (!c_reg[OUT-1].in_brush)
                out_w_reg <= c_reg[OUT-1].w;
            else if (nd_sum_reg[bbwp_pkg::ND_STEPS-1] == '0)
                out_w_reg <= '0;
            else
                out_w_reg <= nd_q_reg[bbwp_pkg::ND_STEPS-1];
        end
    end

    assign new_weight_0 = out_w_reg[0];
    assign new_weight_1 = out_w_reg[1];
    assign new_weight_2 = out_w_reg[2];
    assign new_weight_3 = out_w_reg[3];
    assign new_weight_4 = out_w_reg[4];
    assign new_weight_5 = out_w_reg[5];
    assign new_weight_6 = out_w_reg[6];
    assign new_weight_7 = out_w_reg[7];
    assign painted      = painted_reg;

endmodule
